### rtl/qrn_pkg.sv
package qrn_pkg;

  localparam int DATA_W     = 32;
  localparam int TOL_W      = 16;
  localparam int MAG_W      = 33;
  localparam int REM_W      = 65;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  localparam logic OP_ROTATE    = 1'b0;
  localparam logic OP_NORMALIZE = 1'b1;

  // pipeline depths of the two datapaths
  localparam int ROT_LAT = 7;
  localparam int NRM_LAT = 9 + 2 * SQRT_STEPS + DIV_STEPS;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } qrn_in_t;

  typedef struct packed {
    logic signed [31:0] res_a;
    logic signed [31:0] res_b;
    logic signed [31:0] res_c;
    logic signed [31:0] res_d;
    logic               status;
  } qrn_out_t;

  // one square-root lane: running remainder and partial root
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } qrn_sqrt_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x[67:31] == {37{x[67]}}) begin
      return x[31:0];
    end else if (x[67]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

### rtl/quaternion_rotate_normalize_core.sv
// Quaternion unit, signed fixed point with FRAC_BITS fraction bits (Q15.16
// by default). An item is taken on every clock edge where start is high;
// busy is always low, so one item per cycle streams in with no gaps. Each
// item gives exactly one result, shown on out_data for one cycle with
// out_valid high, in input order. There is no backpressure: the receiver
// must capture every strobe. The depth is set by the normalize path, a
// chain of one-bit cells: 32 square-root cells for the magnitude, 32
// restoring-divide cells for the four components, and 32 more square-root
// cells for the check magnitude. Rotations run through a 7-stage
// multiplier pipeline and are delayed to the same depth. cfg_wdata loads
// the unit tolerance (reset 66) on cfg_we; write it only with no items
// in flight.
module quaternion_rotate_normalize_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  qrn_pkg::qrn_in_t           in_data,
  input  logic                       cfg_we,
  input  logic [qrn_pkg::TOL_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output qrn_pkg::qrn_out_t          out_data
);
  import qrn_pkg::*;

  localparam int ROT_DLY = NRM_LAT - ROT_LAT;

  logic [TOL_W-1:0]   tol_r;
  logic [NRM_LAT-1:0] vld_r;     // transfer marker per stage
  logic [NRM_LAT-1:0] op_r;      // operation per stage
  logic               accept;
  qrn_out_t           rot_res, nrm_res;
  qrn_out_t           dly_r [ROT_DLY];
  logic               out_valid_r;
  qrn_out_t           out_data_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  qrn_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk   (clk),
    .in_i  (in_data),
    .out_o (rot_res)
  );

  qrn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk   (clk),
    .in_i  (in_data),
    .tol_i (tol_r),
    .out_o (nrm_res)
  );

  // control: tolerance register, valid and opcode lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      vld_r       <= {vld_r[NRM_LAT-2:0], accept};
      out_valid_r <= vld_r[NRM_LAT-1];
    end
  end

  // payload: rotate results wait for the longer normalize path
  always_ff @(posedge clk) begin
    op_r     <= {op_r[NRM_LAT-2:0], in_data.operation};
    dly_r[0] <= rot_res;
    for (int i = 1; i < ROT_DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
    out_data_r <= (op_r[NRM_LAT-1] == OP_NORMALIZE) ? nrm_res : dly_r[ROT_DLY-1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/qrn_sqrt_cell.sv
module qrn_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  qrn_pkg::qrn_sqrt_t lane_i,
  input  logic [SIDE_W-1:0]  side_i,
  output qrn_pkg::qrn_sqrt_t lane_o,
  output logic [SIDE_W-1:0]  side_o
);
  import qrn_pkg::*;

  localparam logic [63:0] BIT = 64'd1 << (2 * STEP);

  qrn_sqrt_t   lane_r, lane_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [63:0] trial;

  // one root bit per cell
  always_comb begin
    trial = lane_i.root + BIT;
    if (lane_i.rem >= trial) begin
      lane_nxt.rem  = lane_i.rem - trial;
      lane_nxt.root = (lane_i.root >> 1) + BIT;
    end else begin
      lane_nxt.rem  = lane_i.rem;
      lane_nxt.root = lane_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    side_r <= side_i;
  end

  assign lane_o = lane_r;
  assign side_o = side_r;

endmodule

### rtl/qrn_div_cell.sv
module qrn_div_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic [qrn_pkg::MAG_W-1:0]         mag_i,
  input  logic [3:0][qrn_pkg::REM_W-1:0]    rem_i,
  input  logic [3:0][qrn_pkg::DATA_W-1:0]   quo_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic [qrn_pkg::MAG_W-1:0]         mag_o,
  output logic [3:0][qrn_pkg::REM_W-1:0]    rem_o,
  output logic [3:0][qrn_pkg::DATA_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import qrn_pkg::*;

  logic [MAG_W-1:0]         mag_r;
  logic [3:0][REM_W-1:0]    rem_r, rem_nxt;
  logic [3:0][DATA_W-1:0]   quo_r, quo_nxt;
  logic [SIDE_W-1:0]        side_r;
  logic [REM_W-1:0]         dvs;

  // restoring step, one quotient bit for each of four lanes
  always_comb begin
    dvs = REM_W'(mag_i) << STEP;
    for (int l = 0; l < 4; l++) begin
      rem_nxt[l] = rem_i[l];
      quo_nxt[l] = quo_i[l];
      if (rem_i[l] >= dvs) begin
        rem_nxt[l]       = rem_i[l] - dvs;
        quo_nxt[l][STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_i;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign mag_o  = mag_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

### rtl/qrn_rot.sv
module qrn_rot #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  qrn_pkg::qrn_in_t  in_i,
  output qrn_pkg::qrn_out_t out_o
);
  import qrn_pkg::*;

  localparam logic signed [65:0] HALF_T = 66'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [65:0] HALF_Q = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] HALF_W = 65'sd1 <<< (FRAC_BITS - 1);

  qrn_in_t d1_r, d2_r, d3_r, d4_r, d5_r, d6_r;

  logic signed [63:0] p1_r [6];
  logic signed [63:0] p1_nxt [6];
  logic signed [64:0] c2_r [3];
  logic signed [31:0] t3_r [3];
  logic signed [31:0] t3_nxt [3];
  logic signed [63:0] p4_r [6];
  logic signed [63:0] p4_nxt [6];
  logic signed [63:0] wt4_r [3];
  logic signed [63:0] wt4_nxt [3];
  logic signed [64:0] u5_r [3];
  logic signed [64:0] wr5_r [3];
  logic signed [64:0] wr5_nxt [3];
  logic signed [65:0] qt6_r [3];
  logic signed [65:0] qt6_nxt [3];
  logic signed [64:0] wr6_r [3];
  logic signed [31:0] r7_r [3];
  logic signed [31:0] r7_nxt [3];
  logic signed [65:0] tr;
  logic signed [31:0] qv [3];

  // first cross product, q x v
  always_comb begin
    p1_nxt[0] = $signed(in_i.quat_y) * $signed(in_i.vec_z);
    p1_nxt[1] = $signed(in_i.quat_z) * $signed(in_i.vec_y);
    p1_nxt[2] = $signed(in_i.quat_z) * $signed(in_i.vec_x);
    p1_nxt[3] = $signed(in_i.quat_x) * $signed(in_i.vec_z);
    p1_nxt[4] = $signed(in_i.quat_x) * $signed(in_i.vec_y);
    p1_nxt[5] = $signed(in_i.quat_y) * $signed(in_i.vec_x);
  end

  // t = 2 (q x v), rounded
  always_comb begin
    tr = '0;
    for (int i = 0; i < 3; i++) begin
      tr        = (66'(c2_r[i]) + HALF_T) >>> (FRAC_BITS - 1);
      t3_nxt[i] = sat32(68'(tr));
    end
  end

  // second cross product q x t and w t
  always_comb begin
    p4_nxt[0]  = $signed(d3_r.quat_y) * t3_r[2];
    p4_nxt[1]  = $signed(d3_r.quat_z) * t3_r[1];
    p4_nxt[2]  = $signed(d3_r.quat_z) * t3_r[0];
    p4_nxt[3]  = $signed(d3_r.quat_x) * t3_r[2];
    p4_nxt[4]  = $signed(d3_r.quat_x) * t3_r[1];
    p4_nxt[5]  = $signed(d3_r.quat_y) * t3_r[0];
    for (int i = 0; i < 3; i++) begin
      wt4_nxt[i] = $signed(d3_r.quat_w) * t3_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr5_nxt[i] = (65'(wt4_r[i]) + HALF_W) >>> FRAC_BITS;
      qt6_nxt[i] = (66'(u5_r[i]) + HALF_Q) >>> FRAC_BITS;
    end
  end

  assign qv[0] = d6_r.vec_x;
  assign qv[1] = d6_r.vec_y;
  assign qv[2] = d6_r.vec_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r7_nxt[i] = sat32(68'(qv[i]) + 68'(wr6_r[i]) + 68'(qt6_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    d1_r <= in_i;
    d2_r <= d1_r;
    d3_r <= d2_r;
    d4_r <= d3_r;
    d5_r <= d4_r;
    d6_r <= d5_r;
    for (int i = 0; i < 6; i++) begin
      p1_r[i] <= p1_nxt[i];
      p4_r[i] <= p4_nxt[i];
    end
    for (int i = 0; i < 3; i++) begin
      c2_r[i]  <= 65'(p1_r[2*i]) - 65'(p1_r[2*i+1]);
      t3_r[i]  <= t3_nxt[i];
      wt4_r[i] <= wt4_nxt[i];
      u5_r[i]  <= 65'(p4_r[2*i]) - 65'(p4_r[2*i+1]);
      wr5_r[i] <= wr5_nxt[i];
      qt6_r[i] <= qt6_nxt[i];
      wr6_r[i] <= wr5_r[i];
      r7_r[i]  <= r7_nxt[i];
    end
  end

  assign out_o.res_a  = r7_r[0];
  assign out_o.res_b  = r7_r[1];
  assign out_o.res_c  = r7_r[2];
  assign out_o.res_d  = '0;
  assign out_o.status = 1'b0;

endmodule

### rtl/qrn_norm.sv
module qrn_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  qrn_pkg::qrn_in_t           in_i,
  input  logic [qrn_pkg::TOL_W-1:0]  tol_i,
  output qrn_pkg::qrn_out_t          out_o
);
  import qrn_pkg::*;

  localparam int QV_W  = 4 * DATA_W;
  localparam int SA_W  = QV_W + 1;
  localparam int SB_W  = QV_W + 2;
  localparam int DS_W  = 9;
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(1) << DATA_W;
  localparam logic [MAG_W-1:0] ONE     = MAG_W'(1) << FRAC_BITS;

  logic [3:0][DATA_W-1:0] qin;
  logic [3:0][63:0]       sq1_r, sq1_nxt;
  logic [3:0][DATA_W-1:0] q1_r, q2_r, q3_r;
  logic [64:0]            sum2;
  logic [63:0]            sum2_r;
  logic                   big2_r;

  qrn_sqrt_t        sa_lane [SQRT_STEPS+1];
  logic [SA_W-1:0]  sa_side [SQRT_STEPS+1];
  logic [MAG_W-1:0] mag3_r, mag3_nxt;

  logic [3:0][REM_W-1:0]  rem4_nxt;
  logic [3:0]             ovf4_nxt, neg4_nxt;
  logic [DATA_W-1:0]      absq;

  logic [MAG_W-1:0]          dv_mag  [DIV_STEPS+1];
  logic [3:0][REM_W-1:0]     dv_rem  [DIV_STEPS+1];
  logic [3:0][DATA_W-1:0]    dv_quo  [DIV_STEPS+1];
  logic [DS_W-1:0]           dv_side [DIV_STEPS+1];

  logic [3:0][DATA_W-1:0] r5_r, r5_nxt, r6_r;
  logic                   z5_r, z6_r;
  logic [3:0][63:0]       sq6_r, sq6_nxt;
  logic [64:0]            sum7;
  logic [63:0]            sum7_r;
  logic                   big7_r;
  logic [3:0][DATA_W-1:0] r7_r;
  logic                   z7_r;

  qrn_sqrt_t        sb_lane [SQRT_STEPS+1];
  logic [SB_W-1:0]  sb_side [SQRT_STEPS+1];
  logic [MAG_W-1:0] m8_r, m8_nxt;
  logic [3:0][DATA_W-1:0] r8_r;
  logic                   z8_r;
  logic [MAG_W-1:0] diff;
  qrn_out_t         out_r;

  assign qin = {in_i.quat_w, in_i.quat_x, in_i.quat_y, in_i.quat_z};

  // squares and sum of squares
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq1_nxt[i] = $signed(qin[i]) * $signed(qin[i]);
      sq6_nxt[i] = $signed(r5_r[i]) * $signed(r5_r[i]);
    end
  end

  assign sum2 = 65'(sq1_r[0]) + 65'(sq1_r[1]) + 65'(sq1_r[2]) + 65'(sq1_r[3]);
  assign sum7 = 65'(sq6_r[0]) + 65'(sq6_r[1]) + 65'(sq6_r[2]) + 65'(sq6_r[3]);

  // magnitude of q
  assign sa_lane[0] = '{rem: sum2_r, root: '0};
  assign sa_side[0] = {big2_r, q2_r};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt_a
    qrn_sqrt_cell #(.STEP(SQRT_STEPS - 1 - g), .SIDE_W(SA_W)) u_cell (
      .clk    (clk),
      .lane_i (sa_lane[g]),
      .side_i (sa_side[g]),
      .lane_o (sa_lane[g+1]),
      .side_o (sa_side[g+1])
    );
  end

  // round to nearest; a sum of 2^64 gives exactly 2^32
  always_comb begin
    if (sa_side[SQRT_STEPS][SA_W-1]) begin
      mag3_nxt = MAG_MAX;
    end else begin
      mag3_nxt = MAG_W'(sa_lane[SQRT_STEPS].root[DATA_W-1:0])
               + MAG_W'(sa_lane[SQRT_STEPS].rem > sa_lane[SQRT_STEPS].root);
    end
  end

  // dividends |a| 2^F + mag/2, and quotients of 2^32 or more up front
  always_comb begin
    absq = '0;
    for (int i = 0; i < 4; i++) begin
      neg4_nxt[i] = q3_r[i][DATA_W-1];
      absq        = neg4_nxt[i] ? DATA_W'(-q3_r[i]) : q3_r[i];
      rem4_nxt[i] = (REM_W'(absq) << FRAC_BITS) + REM_W'(mag3_r >> 1);
      ovf4_nxt[i] = rem4_nxt[i] >= (REM_W'(mag3_r) << DATA_W);
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    qrn_div_cell #(.STEP(DIV_STEPS - 1 - g), .SIDE_W(DS_W)) u_cell (
      .clk    (clk),
      .mag_i  (dv_mag[g]),
      .rem_i  (dv_rem[g]),
      .quo_i  (dv_quo[g]),
      .side_i (dv_side[g]),
      .mag_o  (dv_mag[g+1]),
      .rem_o  (dv_rem[g+1]),
      .quo_o  (dv_quo[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  assign dv_quo[0] = '0;

  // sign and clamp; zero magnitude forces zeros
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_side[DIV_STEPS][8]) begin
        r5_nxt[i] = '0;
      end else if (dv_side[DIV_STEPS][i] || dv_quo[DIV_STEPS][i][DATA_W-1]) begin
        r5_nxt[i] = dv_side[DIV_STEPS][4+i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (dv_side[DIV_STEPS][4+i]) begin
        r5_nxt[i] = DATA_W'(-dv_quo[DIV_STEPS][i]);
      end else begin
        r5_nxt[i] = dv_quo[DIV_STEPS][i];
      end
    end
  end

  // magnitude of the normalized quaternion
  assign sb_lane[0] = '{rem: sum7_r, root: '0};
  assign sb_side[0] = {z7_r, big7_r, r7_r};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt_b
    qrn_sqrt_cell #(.STEP(SQRT_STEPS - 1 - g), .SIDE_W(SB_W)) u_cell (
      .clk    (clk),
      .lane_i (sb_lane[g]),
      .side_i (sb_side[g]),
      .lane_o (sb_lane[g+1]),
      .side_o (sb_side[g+1])
    );
  end

  always_comb begin
    if (sb_side[SQRT_STEPS][SB_W-2]) begin
      m8_nxt = MAG_MAX;
    end else begin
      m8_nxt = MAG_W'(sb_lane[SQRT_STEPS].root[DATA_W-1:0])
             + MAG_W'(sb_lane[SQRT_STEPS].rem > sb_lane[SQRT_STEPS].root);
    end
  end

  assign diff = (m8_r > ONE) ? (m8_r - ONE) : (ONE - m8_r);

  always_ff @(posedge clk) begin
    sq1_r      <= sq1_nxt;
    q1_r       <= qin;
    sum2_r     <= sum2[63:0];
    big2_r     <= sum2[64];
    q2_r       <= q1_r;
    mag3_r     <= mag3_nxt;
    q3_r       <= sa_side[SQRT_STEPS][QV_W-1:0];
    dv_mag[0]  <= mag3_r;
    dv_rem[0]  <= rem4_nxt;
    dv_side[0] <= {(mag3_r == '0), neg4_nxt, ovf4_nxt};
    r5_r       <= r5_nxt;
    z5_r       <= dv_side[DIV_STEPS][8];
    sq6_r      <= sq6_nxt;
    r6_r       <= r5_r;
    z6_r       <= z5_r;
    sum7_r     <= sum7[63:0];
    big7_r     <= sum7[64];
    r7_r       <= r6_r;
    z7_r       <= z6_r;
    m8_r       <= m8_nxt;
    r8_r       <= sb_side[SQRT_STEPS][QV_W-1:0];
    z8_r       <= sb_side[SQRT_STEPS][SB_W-1];
    out_r.res_a  <= r8_r[3];
    out_r.res_b  <= r8_r[2];
    out_r.res_c  <= r8_r[1];
    out_r.res_d  <= r8_r[0];
    out_r.status <= z8_r || (diff > MAG_W'(tol_i));
  end

  assign out_o = out_r;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import qrn_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam int DRAIN_CYC = NRM_LAT + 12;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic     known;
    qrn_out_t res;
  } row_tag_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  qrn_in_t          in_data;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  logic             out_valid;
  qrn_out_t         out_data;

  logic [TOL_W-1:0] tol_shadow;
  qrn_out_t         pending_q[$];   // expected results, oldest first
  row_tag_t         tag_q[$];       // per sent item: typed-in result or not
  int               err_cnt;
  bit               gaps_on;

  quaternion_rotate_normalize_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------
  // floor((v + half) / 2^s)
  function automatic wide_t rnd_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t clip32(wide_t v);
    if (v > wide_t'(S_MAX)) return wide_t'(S_MAX);
    if (v < wide_t'(S_MIN)) return wide_t'(S_MIN);
    return v;
  endfunction

  function automatic wide_t xterm(wide_t a1, wide_t b2, wide_t a2, wide_t b1);
    return a1 * b2 - a2 * b1;
  endfunction

  // root of a sum of squares, rounded to nearest
  function automatic wide_t root_near(wide_t s);
    wide_t r;
    wide_t cand;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = r | (wide_t'(1) <<< b);
      if (cand * cand <= s) r = cand;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic wide_t quat_mag(wide_t c0, wide_t c1, wide_t c2, wide_t c3);
    return root_near(c0 * c0 + c1 * c1 + c2 * c2 + c3 * c3);
  endfunction

  function automatic qrn_out_t predict_quat(qrn_in_t it, logic [TOL_W-1:0] tol);
    qrn_out_t o;
    wide_t q[4];
    wide_t v[3];
    wide_t c[3];
    wide_t t[3];
    wide_t u[3];
    wide_t r[4];
    wide_t mag, a, n, sn, m2, diff;
    q[0] = it.quat_w; q[1] = it.quat_x; q[2] = it.quat_y; q[3] = it.quat_z;
    v[0] = it.vec_x;  v[1] = it.vec_y;  v[2] = it.vec_z;
    for (int i = 0; i < 4; i++) r[i] = 0;
    o.status = 1'b0;
    if (it.operation == OP_ROTATE) begin
      c[0] = xterm(q[2], v[2], q[3], v[1]);
      c[1] = xterm(q[3], v[0], q[1], v[2]);
      c[2] = xterm(q[1], v[1], q[2], v[0]);
      for (int i = 0; i < 3; i++) t[i] = clip32(rnd_shift(c[i], FRAC - 1));
      u[0] = xterm(q[2], t[2], q[3], t[1]);
      u[1] = xterm(q[3], t[0], q[1], t[2]);
      u[2] = xterm(q[1], t[1], q[2], t[0]);
      for (int i = 0; i < 3; i++)
        r[i] = clip32(v[i] + rnd_shift(q[0] * t[i], FRAC) + rnd_shift(u[i], FRAC));
    end else begin
      mag = quat_mag(q[0], q[1], q[2], q[3]);
      if (mag == 0) begin
        o.status = 1'b1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          a  = (q[i] < 0) ? -q[i] : q[i];
          n  = ((a <<< FRAC) + (mag >>> 1)) / mag;
          sn = (n > wide_t'(S_MAX)) ? wide_t'(S_MAX) + 1 : n;
          r[i] = clip32((q[i] < 0) ? -sn : sn);
        end
        m2   = quat_mag(r[0], r[1], r[2], r[3]);
        diff = (m2 > (wide_t'(1) <<< FRAC)) ? m2 - (wide_t'(1) <<< FRAC)
                                            : (wide_t'(1) <<< FRAC) - m2;
        if (diff > wide_t'(tol)) o.status = 1'b1;
      end
    end
    o.res_a = r[0][31:0];
    o.res_b = r[1][31:0];
    o.res_c = r[2][31:0];
    o.res_d = r[3][31:0];
    return o;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Transfers are seen with pre-edge values, so DUT updates in the same
  // step cannot race the sampling.
  always @(posedge clk) begin
    qrn_out_t w;
    row_tag_t tg;
    if (rst_n && cfg_we) tol_shadow = cfg_wdata;
    if (rst_n && start && !busy) begin
      tg = tag_q.pop_front();
      pending_q.push_back(tg.known ? tg.res : predict_quat(in_data, tol_shadow));
    end
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("tb: unexpected result at %0t", $realtime);
        err_cnt++;
      end else begin
        w = pending_q.pop_front();
        if (out_data.res_a !== w.res_a) report_mismatch("res_a", out_data.res_a, w.res_a);
        if (out_data.res_b !== w.res_b) report_mismatch("res_b", out_data.res_b, w.res_b);
        if (out_data.res_c !== w.res_c) report_mismatch("res_c", out_data.res_c, w.res_c);
        if (out_data.res_d !== w.res_d) report_mismatch("res_d", out_data.res_d, w.res_d);
        if (out_data.status !== w.status)
          report_mismatch("status", 32'(out_data.status), 32'(w.status));
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic qrn_in_t mk_item(logic op, logic signed [31:0] w, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z,
                                      logic signed [31:0] vx, logic signed [31:0] vy,
                                      logic signed [31:0] vz);
    qrn_in_t it;
    it.operation = op;
    it.quat_w = w; it.quat_x = x; it.quat_y = y; it.quat_z = z;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
    return it;
  endfunction

  function automatic qrn_out_t mk_res(logic signed [31:0] a, logic signed [31:0] b,
                                      logic signed [31:0] c, logic signed [31:0] d,
                                      logic st);
    qrn_out_t o;
    o.res_a = a; o.res_b = b; o.res_c = c; o.res_d = d; o.status = st;
    return o;
  endfunction

  // mix of extremes, near-unit values and raw random words
  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 5))
           0: return S_MIN;
           1: return S_MAX;
           2: return 32'sd0;
           3: return -32'sd1;
           4: return ONE_Q;
           default: return -ONE_Q;
         endcase
      1, 2: return $signed($urandom_range(0, 32'h0002_0000)) - ONE_Q;
      3: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  // start stays high across back-to-back items: one NBA per step
  task automatic send_item(qrn_in_t it, logic known, qrn_out_t res);
    row_tag_t tg;
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tg.known = known;
    tg.res   = res;
    tag_q.push_back(tg);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_tol(logic [TOL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------- main sequence ----------------
  qrn_in_t  dir_in[$];
  logic     dir_known[$];
  qrn_out_t dir_res[$];
  qrn_out_t no_res;

  initial begin
    logic [TOL_W-1:0] tol_set[4];
    qrn_in_t it;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    tol_shadow = TOL_RESET;
    err_cnt    = 0;
    gaps_on    = 1'b1;
    no_res     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed results only where they are obvious
    // zero quaternion normalize: zeros and the flag
    dir_in.push_back(mk_item(OP_NORMALIZE, 0, 0, 0, 0, 5, 6, 7));
    dir_known.push_back(1); dir_res.push_back(mk_res(0, 0, 0, 0, 1));
    // unit quaternion normalizes to itself
    dir_in.push_back(mk_item(OP_NORMALIZE, ONE_Q, 0, 0, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(mk_res(ONE_Q, 0, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, 0, 0, 0, -ONE_Q, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(mk_res(0, 0, 0, -ONE_Q, 0));
    // identity rotation passes the vector through, extremes included
    dir_in.push_back(mk_item(OP_ROTATE, ONE_Q, 0, 0, 0, S_MIN, S_MAX, -1));
    dir_known.push_back(1); dir_res.push_back(mk_res(S_MIN, S_MAX, -1, 0, 0));
    // zero quaternion rotate also leaves the vector
    dir_in.push_back(mk_item(OP_ROTATE, 0, 0, 0, 0, S_MAX, 0, S_MIN));
    dir_known.push_back(1); dir_res.push_back(mk_res(S_MAX, 0, S_MIN, 0, 0));
    // largest magnitude: all components at the negative extreme
    dir_in.push_back(mk_item(OP_NORMALIZE, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, S_MAX, S_MAX, S_MAX, S_MAX, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, S_MIN, 0, 0, 0, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, 1, 1, 1, -1, 0, 0, 0));
    dir_in.push_back(mk_item(OP_NORMALIZE, 3, 4, 0, 0, 0, 0, 0));
    // rotations that saturate
    dir_in.push_back(mk_item(OP_ROTATE, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX));
    dir_in.push_back(mk_item(OP_ROTATE, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
    dir_in.push_back(mk_item(OP_ROTATE, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
    // 90 degree turn about z, and rounding at the half step
    dir_in.push_back(mk_item(OP_ROTATE, 32'sd46341, 0, 0, 32'sd46341, ONE_Q, 0, 0));
    dir_in.push_back(mk_item(OP_ROTATE, 1, 1, 1, 1, 1, -1, 1));
    dir_in.push_back(mk_item(OP_ROTATE, -1, 32'sd32768, -32'sd32768, 1, 3, 5, -7));
    dir_in.push_back(mk_item(OP_ROTATE, 0, ONE_Q, 0, 0, 0, ONE_Q, 0));
    while (dir_known.size() < dir_in.size()) begin
      dir_known.push_back(0);
      dir_res.push_back(no_res);
    end
    foreach (dir_in[i]) send_item(dir_in[i], dir_known[i], dir_res[i]);
    drain();

    // random phases across tolerance settings, extremes first
    tol_set[0] = 16'd0;
    tol_set[1] = 16'hFFFF;
    tol_set[2] = 16'($urandom_range(1, 2000));
    tol_set[3] = TOL_RESET;
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(tol_set[ph]);
      if (ph == 3) gaps_on = 1'b0;   // back-to-back stretch at the end
      for (int k = 0; k < 200; k++) begin
        it = mk_item(1'($urandom_range(0, 1)), pick_val(), pick_val(), pick_val(),
                     pick_val(), pick_val(), pick_val(), pick_val());
        // every so often hit the zero quaternion
        if ($urandom_range(0, 40) == 0) begin
          it.quat_w = 0; it.quat_x = 0; it.quat_y = 0; it.quat_z = 0;
        end
        send_item(it, 1'b0, no_res);
      end
      drain();
    end

    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
